[design/sbe_pkg.sv]
// shared types and constants for the set-bit expansion block
package sbe_pkg;

  localparam int unsigned ValueW       = 63;
  localparam int unsigned MaskW        = 64;
  localparam int unsigned IdxW         = 6;
  localparam int unsigned FlatW        = 32;
  localparam int unsigned WinW         = 8;
  localparam int unsigned WinSelW      = 3;
  localparam int unsigned ShiftW       = 4;
  localparam int unsigned PositionBits = 32;

  typedef struct packed {
    logic [ValueW-1:0] base_value;
    logic [MaskW-1:0]  bit_mask;
    logic              batch_start;
  } in_req_t;

  typedef struct packed {
    logic [IdxW-1:0]         bit_index;
    logic signed [MaskW-1:0] difference;
    logic [FlatW-1:0]        flat_position;
    logic                    last_of_item;
  } out_req_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } sbe_state_e;

  // control from the sequencer into the scan unit
  typedef struct packed {
    logic             load;
    logic [MaskW-1:0] load_mask;
    logic             emit_ok;
  } scan_ctl_t;

  // status from the scan unit back to the sequencer
  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] bit_index;
    logic            last;
  } scan_sts_t;

endpackage

[design/set_bit_expand_subtract_pow2_top.sv]
// top level of the set-bit expansion block: sequencer, subtractor, position counter
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------
//   in      | in        | in_valid_i / in_stall_o | in_req_i  (in_req_t)
//   out     | out       | out_valid_o/ out_stall_i| out_req_o (out_req_t)
//
// an item is accepted, then one result is emitted per set bit, lowest first,
// with runs of eight clear bits in the scan window skipped at once; no new item
// is taken until its last result is emitted; the single 64-bit subtractor serves all bits
// a zero mask item is done in its accept cycle and only applies batch_start
// reset clears the sequencer, the running position and the output valid
// a stalled output holds the result register and pauses the scan at the next set bit
module set_bit_expand_subtract_pow2_top #(
  parameter int unsigned POSITION_BITS = sbe_pkg::PositionBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sbe_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sbe_pkg::out_req_t out_req_o
);
  import sbe_pkg::*;

  sbe_state_e state_q, state_d;
  scan_ctl_t  scan_ctl;
  scan_sts_t  scan_sts;

  // operand held for the whole item
  logic [ValueW-1:0]        base_q, base_d;
  // running flat position, wraps at its own width
  logic [POSITION_BITS-1:0] pos_q, pos_d;

  logic     out_valid_q, out_valid_d;
  out_req_t out_q, out_d;

  logic accept;
  logic slot_free;
  logic emit;

  logic [MaskW-1:0] pow2;
  logic [MaskW-1:0] diff;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // the result register is free when empty or being drained this cycle
  assign slot_free = !out_valid_q || !out_stall_i;
  assign emit      = (state_q == ST_SCAN) && scan_sts.hit && slot_free;

  assign scan_ctl.load      = accept;
  assign scan_ctl.load_mask = in_req_i.bit_mask;
  assign scan_ctl.emit_ok   = (state_q == ST_SCAN) && slot_free;

  sbe_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (scan_ctl),
    .sts_o  (scan_sts)
  );

  // shared subtractor, p - 2^m wrapping at 64 bits
  assign pow2 = MaskW'(1) << scan_sts.bit_index;
  assign diff = {1'b0, base_q} - pow2;

  // sequencer
  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    pos_d       = pos_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          base_d = in_req_i.base_value;
          if (in_req_i.batch_start) begin
            pos_d = '0;
          end
          // a zero mask emits nothing
          if (in_req_i.bit_mask != '0) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (emit) begin
          out_valid_d         = 1'b1;
          out_d.bit_index     = scan_sts.bit_index;
          out_d.difference    = diff;
          out_d.flat_position = FlatW'(pos_q);
          out_d.last_of_item  = scan_sts.last;
          pos_d               = pos_q + POSITION_BITS'(1);
          if (scan_sts.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

[design/sbe_scan.sv]
// set-bit scanner: remaining mask register with an 8-bit search window
module sbe_scan (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbe_pkg::scan_ctl_t ctl_i,
  output sbe_pkg::scan_sts_t sts_o
);
  import sbe_pkg::*;

  logic [MaskW-1:0]   rem_q, rem_d;
  logic [IdxW-1:0]    base_q, base_d;
  logic [WinW-1:0]    win;
  logic [WinSelW-1:0] sel;
  logic [ShiftW-1:0]  hop;
  logic [MaskW-1:0]   rem_hop;
  logic               hit;

  assign win = rem_q[WinW-1:0];
  assign hit = |win;

  // lowest set bit inside the window
  always_comb begin
    sel = '0;
    for (int i = WinW - 1; i >= 0; i--) begin
      if (win[i]) begin
        sel = WinSelW'(i);
      end
    end
  end

  assign hop     = hit ? (ShiftW'(sel) + ShiftW'(1)) : ShiftW'(WinW);
  assign rem_hop = rem_q >> hop;

  always_comb begin
    rem_d  = rem_q;
    base_d = base_q;
    if (ctl_i.load) begin
      rem_d  = ctl_i.load_mask;
      base_d = '0;
    end else if (!hit || ctl_i.emit_ok) begin
      rem_d  = rem_hop;
      base_d = base_q + IdxW'(hop);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      base_q <= '0;
    end else begin
      rem_q  <= rem_d;
      base_q <= base_d;
    end
  end

  assign sts_o.hit       = hit;
  assign sts_o.bit_index = base_q + IdxW'(sel);
  assign sts_o.last      = (rem_hop == '0);

endmodule

[tb/set_bit_expand_subtract_pow2_top_tb.sv]
`timescale 1ns / 1ps
// testbench for the set-bit expansion block: directed, back-to-back, backpressure, random
module set_bit_expand_subtract_pow2_top_tb;
  import sbe_pkg::*;

  localparam int unsigned PosBits = sbe_pkg::PositionBits;
  // slowest item: a mask with all 64 bits set, with some margin
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned MaxIdle = 6;
  localparam int unsigned HoldOffCycles = 400;

  // shapes of random masks, chosen so that dense, sparse and gapped scans all occur
  typedef enum int unsigned {
    SHAPE_ZERO,
    SHAPE_ONE_HOT,
    SHAPE_SPARSE,
    SHAPE_DENSE,
    SHAPE_WINDOWS,
    SHAPE_FULL_RANDOM,
    SHAPE_COUNT
  } mask_shape_e;

  logic     clk_i;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_req_t out_req_o;

  // expected results in order, and the running position they are numbered from
  out_req_t             expected_bits[$];
  logic [PosBits-1:0]   batch_position = '0;
  int unsigned          mismatch_count = 0;

  // idling control for the sender and the receiver
  logic        tx_idle_en = 1'b0;
  logic        rx_idle_en = 1'b0;
  int unsigned rx_wait = 0;
  int unsigned hold_cycles = 0;

  set_bit_expand_subtract_pow2_top #(
    .POSITION_BITS(PosBits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // safety net against a hung block
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // one result per set bit, lowest first; batch_start clears the count first
  function automatic void expand_mask(input in_req_t req);
    logic [MaskW-1:0] rest;
    out_req_t         r;
    if (req.batch_start) batch_position = '0;
    rest = req.bit_mask;
    for (int m = 0; m < MaskW; m++) begin
      if (rest[m]) begin
        rest[m]         = 1'b0;
        r.bit_index     = IdxW'(m);
        // value is zero-extended, subtraction wraps at 64 bits
        r.difference    = {1'b0, req.base_value} - (64'd1 << m);
        r.flat_position = FlatW'(batch_position);
        r.last_of_item  = (rest == '0);
        batch_position  = batch_position + 1'b1;
        expected_bits.push_back(r);
      end
    end
  endfunction

  // receiver: a long hold-off when asked, else a per-result random wait
  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (rx_wait != 0) begin
      out_stall_i <= 1'b1;
      rx_wait     <= rx_wait - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk_i) begin
    out_req_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bits.size() == 0) begin
        $error("result with no request pending: index %0d", out_req_o.bit_index);
        mismatch_count++;
      end else begin
        exp_r = expected_bits.pop_front();
        if (out_req_o.bit_index !== exp_r.bit_index) begin
          $error("bit_index: expected %0d, actual %0d", exp_r.bit_index,
                 out_req_o.bit_index);
          mismatch_count++;
        end
        if (out_req_o.difference !== exp_r.difference) begin
          $error("difference: expected %0h, actual %0h", exp_r.difference,
                 out_req_o.difference);
          mismatch_count++;
        end
        if (out_req_o.flat_position !== exp_r.flat_position) begin
          $error("flat_position: expected %0d, actual %0d", exp_r.flat_position,
                 out_req_o.flat_position);
          mismatch_count++;
        end
        if (out_req_o.last_of_item !== exp_r.last_of_item) begin
          $error("last_of_item: expected %0b, actual %0b", exp_r.last_of_item,
                 out_req_o.last_of_item);
          mismatch_count++;
        end
      end
      // wait for the next result is drawn here, counted down by the receiver
      rx_wait = rx_idle_en ? $urandom_range(0, MaxIdle) : 0;
    end
  end

  // drive one request at the falling edge and hold it until accepted
  task automatic send_request(input in_req_t req);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, MaxIdle) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_req_i   <= req;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    expand_mask(req);
  endtask

  function automatic in_req_t make_req(input logic [ValueW-1:0] value,
                                       input logic [MaskW-1:0] mask,
                                       input logic start);
    in_req_t req;
    req.base_value  = value;
    req.bit_mask    = mask;
    req.batch_start = start;
    return req;
  endfunction

  function automatic in_req_t random_request();
    logic [MaskW-1:0]  mask;
    logic [ValueW-1:0] value;
    int unsigned       pick;
    mask_shape_e       shape;
    shape = mask_shape_e'($urandom_range(0, SHAPE_COUNT - 1));
    case (shape)
      SHAPE_ZERO:    mask = '0;
      SHAPE_ONE_HOT: mask = 64'd1 << $urandom_range(0, MaskW - 1);
      SHAPE_SPARSE:  mask = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      SHAPE_DENSE:   mask = {$urandom, $urandom} | {$urandom, $urandom};
      SHAPE_WINDOWS: begin
        // one to three random bytes, the other windows empty
        mask = '0;
        repeat ($urandom_range(1, 3)) mask[8 * $urandom_range(0, 7) +: 8] = 8'($urandom);
      end
      default:       mask = {$urandom, $urandom};
    endcase
    pick = $urandom_range(0, 7);
    if (pick == 0) value = '0;
    else if (pick == 1) value = '1;
    else if (pick == 2) value = ValueW'($urandom_range(0, 255));
    else value = ValueW'({$urandom, $urandom});
    return make_req(value, mask, $urandom_range(0, 7) == 0);
  endfunction

  // field extremes, zero masks, wrapping differences and batch restarts
  task automatic test_directed_edges();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_request(make_req('0, '0, 1'b0));                      // nothing out, position kept
    send_request(make_req('0, 64'd1, 1'b0));                   // 0 - 1 wraps to all ones
    send_request(make_req('0, 64'h8000_0000_0000_0000, 1'b0)); // most negative difference
    send_request(make_req('1, 64'h8000_0000_0000_0000, 1'b0));
    send_request(make_req('1, '1, 1'b0));                      // every bit set
    send_request(make_req('0, '1, 1'b0));
    send_request(make_req('0, '0, 1'b1));                      // zero mask still restarts batch
    send_request(make_req(63'h2AAA_AAAA_AAAA_AAAA, 64'h8000_0000_0000_0001, 1'b0));
    send_request(make_req(63'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0));
    send_request(make_req(63'h2AAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1));
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_request(make_req(63'd1, 64'h0101_0101_0101_0101, 1'b0)); // one bit per window
    send_request(make_req(63'd2, 64'h8080_8080_8080_8080, 1'b0));
    send_request(make_req(63'h4000_0000_0000_0000, 64'h4000_0000_0000_0000, 1'b0));
    send_request(make_req('1, 64'hFF00_0000_0000_0000, 1'b1));
    send_request(make_req(63'd7, 64'h0000_0000_0000_00FF, 1'b0));
    send_request(make_req('0, '0, 1'b0));
    send_request(make_req(63'h1234_5678_9ABC_DEF0, 64'h0000_0001_0000_0000, 1'b0));
    send_request(make_req(63'd0, 64'h0000_0000_0000_0002, 1'b1));
    send_request(make_req('1, '1, 1'b1));
    send_request(make_req(63'd3, 64'h0000_0000_0000_0001, 1'b0));
  endtask

  // no idling on either side
  task automatic test_back_to_back();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (30) send_request(random_request());
  endtask

  // receiver holds off while dense requests keep coming, so the input stalls
  task automatic test_output_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    hold_cycles = HoldOffCycles;
    repeat (12) send_request(make_req(ValueW'({$urandom, $urandom}),
                                      {$urandom, $urandom} | {$urandom, $urandom},
                                      $urandom_range(0, 3) == 0));
  endtask

  // bulk of the run, random idling on both sides
  task automatic test_random_masks();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (400) send_request(random_request());
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_edges();
    test_back_to_back();
    test_output_backpressure();
    test_random_masks();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    rx_idle_en = 1'b0;

    // drain, then watch for stray results
    while (expected_bits.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (expected_bits.size() != 0) begin
      $error("%0d expected results never arrived", expected_bits.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
